@@ sv/curtain_command_controller_macros.svh @@
// Assertion macros shared by the curtain command controller RTL.
// Depends on clk_i and rst_ni being visible in the module that uses them.
`ifndef CURTAIN_COMMAND_CONTROLLER_MACROS_SVH
`define CURTAIN_COMMAND_CONTROLLER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CCC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define CCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ccc_pkg.sv @@
// Curtain command controller package: item types, codes and reset constants.
// No dependencies; used by the interfaces and all modules.
package ccc_pkg;

  localparam int SceneSlotsDef = 3;

  // Input operations and result kinds
  localparam logic OpFrame    = 1'b0;
  localparam logic OpTick     = 1'b1;
  localparam logic KindReply  = 1'b0;
  localparam logic KindDone   = 1'b1;

  // Frame commands
  localparam logic [7:0] CmdPair   = 8'h61; // 'a'
  localparam logic [7:0] CmdMove   = 8'h6f; // 'o'
  localparam logic [7:0] CmdStatus = 8'h70; // 'p'
  localparam logic [7:0] CmdScene  = 8'h71; // 'q'

  // Reply and argument characters
  localparam logic [7:0] ChrTrue    = 8'h54; // 'T'
  localparam logic [7:0] ChrFalse   = 8'h46; // 'F'
  localparam logic [7:0] ChrTerm    = 8'h7c; // '|'
  localparam logic [7:0] ChrOpen    = 8'h61; // 'a'
  localparam logic [7:0] ChrHalf    = 8'h63; // 'c'
  localparam logic [7:0] ChrClosed  = 8'h65; // 'e'
  localparam logic [7:0] ChrQueryA  = 8'h7a; // 'z'
  localparam logic [7:0] ChrQueryB  = 8'h63; // 'c'
  localparam logic [7:0] ChrSlot0   = 8'h61; // 'a'
  localparam logic [7:0] SceneInit0 = 8'h62; // 'b'

  // Curtain positions
  localparam logic [1:0] PosOpen   = 2'd0;
  localparam logic [1:0] PosHalf   = 2'd1;
  localparam logic [1:0] PosClosed = 2'd2;

  localparam logic [1:0] LenShort = 2'd1;
  localparam logic [1:0] LenScene = 2'd3;

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 10;
  localparam logic [CfgIdxW-1:0] CfgDevAddr   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgDevType   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPairCode  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFullTurns = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPulsesPer = 3'd4;

  localparam logic [7:0] DevAddrRst   = 8'd100;
  localparam logic [7:0] DevTypeRst   = 8'd99;
  localparam logic [7:0] PairCodeRst  = 8'd111;
  localparam logic [7:0] FullTurnsRst = 8'd52;
  localparam logic [9:0] PulsesPerRst = 10'd200;

  localparam int PulseW = 18;

  typedef struct packed {
    logic [7:0] own_addr;
    logic [7:0] pair_type;
    logic [7:0] pair_code;
    logic [7:0] full_travel_half_turns;
    logic [9:0] pulses_per_half_turn;
  } ccc_cfg_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] dest_address;
    logic [7:0] cmd_index;
    logic [7:0] command;
    logic [7:0] arg_first;
    logic [7:0] arg_second;
  } ccc_item_t;

  typedef struct packed {
    logic              kind;
    logic [7:0]        reply_index;
    logic [1:0]        payload_len;
    logic [7:0]        payload_first;
    logic [7:0]        payload_second;
    logic [7:0]        payload_third;
    logic              motor_start;
    logic              motor_toward_closed;
    logic [PulseW-1:0] motor_pulses;
  } ccc_result_t;

endpackage

@@ sv/ccc_if.sv @@
// Valid/ready channel interfaces for command items and result items.
// Depends on ccc_pkg for the payload types.
interface ccc_in_if;
  import ccc_pkg::*;
  logic      valid;
  logic      ready;
  ccc_item_t item;
  modport source(output valid, output item, input ready);
  modport sink(input valid, input item, output ready);
endinterface

interface ccc_out_if;
  import ccc_pkg::*;
  logic        valid;
  logic        ready;
  ccc_result_t res;
  modport source(output valid, output res, input ready);
  modport sink(input valid, input res, output ready);
endinterface

@@ sv/ccc_cfg_regs.sv @@
// Configuration register bank of the curtain command controller.
// Depends on ccc_pkg for the register indexes and reset values.
module ccc_cfg_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ccc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [ccc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output ccc_pkg::ccc_cfg_t               cfg_o
);
  import ccc_pkg::*;

  ccc_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_addr               <= DevAddrRst;
      cfg_q.pair_type              <= DevTypeRst;
      cfg_q.pair_code              <= PairCodeRst;
      cfg_q.full_travel_half_turns <= FullTurnsRst;
      cfg_q.pulses_per_half_turn   <= PulsesPerRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDevAddr:   cfg_q.own_addr               <= cfg_wdata_i[7:0];
        CfgDevType:   cfg_q.pair_type              <= cfg_wdata_i[7:0];
        CfgPairCode:  cfg_q.pair_code              <= cfg_wdata_i[7:0];
        CfgFullTurns: cfg_q.full_travel_half_turns <= cfg_wdata_i[7:0];
        CfgPulsesPer: cfg_q.pulses_per_half_turn   <= cfg_wdata_i[9:0];
        default: ; // drop writes beyond the bank
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/ccc_cmd_core.sv @@
// Command decision logic and device state (index, position, scenes, motor count).
// Depends on ccc_pkg and the assertion macro header.
`include "curtain_command_controller_macros.svh"

module ccc_cmd_core #(
  parameter int SCENE_SLOTS = ccc_pkg::SceneSlotsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic                  advance_i,
  input  ccc_pkg::ccc_item_t    item_i,
  input  ccc_pkg::ccc_cfg_t     cfg_i,
  output logic                  res_valid_o,
  output ccc_pkg::ccc_result_t  res_o
);
  import ccc_pkg::*;

  logic [7:0]        last_index_q, last_index_d;
  logic [1:0]        position_q, position_d;
  logic [7:0]        scene_q [SCENE_SLOTS];
  logic [7:0]        scene_d [SCENE_SLOTS];
  logic              running_q, running_d;
  logic [PulseW-1:0] target_q, target_d;
  logic [PulseW-1:0] count_q, count_d;

  logic [1:0]        old_pos, tgt_pos;
  logic              tgt_known, closing, full_dist;
  logic [7:0]        turns;
  logic [PulseW-1:0] pulses;
  logic [7:0]        scene_rd [3];
  logic [7:0]        slot;
  logic [7:0]        pos_letter;

  // Move geometry
  always_comb begin
    old_pos   = (position_q > PosClosed) ? PosClosed : position_q;
    tgt_known = 1'b1;
    case (item_i.arg_first)
      ChrOpen:   tgt_pos = PosOpen;
      ChrHalf:   tgt_pos = PosHalf;
      ChrClosed: tgt_pos = PosClosed;
      default: begin
        tgt_pos   = old_pos;
        tgt_known = 1'b0;
      end
    endcase
    closing   = tgt_pos > old_pos;
    full_dist = (tgt_pos == PosClosed && old_pos == PosOpen)
             || (tgt_pos == PosOpen && old_pos == PosClosed);
    if (tgt_pos == old_pos) begin
      turns = '0;
    end else if (full_dist) begin
      turns = cfg_i.full_travel_half_turns;
    end else begin
      turns = cfg_i.full_travel_half_turns >> 1;
    end
    pulses = {10'b0, turns} * {8'b0, cfg_i.pulses_per_half_turn};
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      scene_rd[j] = '0;
    end
    for (int j = 0; j < SCENE_SLOTS; j++) begin
      if (j < 3) begin
        scene_rd[j] = scene_q[j];
      end
    end
    slot = item_i.arg_first - ChrSlot0;
    if (position_q == PosOpen) begin
      pos_letter = ChrOpen;
    end else if (position_q == PosHalf) begin
      pos_letter = ChrHalf;
    end else begin
      pos_letter = ChrClosed;
    end
  end

  always_comb begin
    last_index_d = last_index_q;
    position_d   = position_q;
    scene_d      = scene_q;
    running_d    = running_q;
    target_d     = target_q;
    count_d      = count_q;
    res_o        = '0;
    res_valid_o  = 1'b0;

    if (item_i.operation == OpTick) begin
      if (running_q) begin
        if (count_q < target_q) begin
          count_d = count_q + 1'b1;
        end else begin
          running_d   = 1'b0;
          res_o.kind  = KindDone;
          res_valid_o = 1'b1;
        end
      end
    end else if (item_i.dest_address == cfg_i.own_addr
                 && item_i.cmd_index != last_index_q) begin
      last_index_d      = item_i.cmd_index;
      res_o.kind        = KindReply;
      res_o.reply_index = item_i.cmd_index;
      res_o.payload_len = LenShort;
      case (item_i.command)
        CmdPair: begin
          res_valid_o = 1'b1;
          res_o.payload_first = (item_i.arg_first == cfg_i.pair_code
                                 && item_i.arg_second == cfg_i.pair_type)
                                ? ChrTrue : ChrFalse;
        end
        CmdMove: begin
          res_valid_o         = 1'b1;
          res_o.payload_first = ChrTrue;
          if (tgt_known) begin
            position_d = tgt_pos;
            if (turns != '0) begin
              target_d  = pulses;
              count_d   = '0;
              running_d = 1'b1;
              res_o.motor_start         = 1'b1;
              res_o.motor_toward_closed = closing;
              res_o.motor_pulses        = pulses;
            end
          end
        end
        CmdStatus: begin
          res_valid_o         = 1'b1;
          res_o.payload_first = pos_letter;
        end
        CmdScene: begin
          res_valid_o = 1'b1;
          if (item_i.arg_first == ChrQueryA && item_i.arg_second == ChrQueryB) begin
            res_o.payload_len    = LenScene;
            res_o.payload_first  = scene_rd[0];
            res_o.payload_second = scene_rd[1];
            res_o.payload_third  = scene_rd[2];
          end else begin
            res_o.payload_first = ChrTrue;
            for (int j = 0; j < SCENE_SLOTS; j++) begin
              if (item_i.arg_first >= ChrSlot0 && slot == 8'(j)) begin
                scene_d[j] = item_i.arg_second;
              end
            end
          end
        end
        default: ; // index is recorded, no reply
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_index_q <= '0;
      position_q   <= PosOpen;
      for (int j = 0; j < SCENE_SLOTS; j++) begin
        scene_q[j] <= (j == 0) ? SceneInit0 : 8'h00;
      end
      running_q <= 1'b0;
      target_q  <= '0;
      count_q   <= '0;
    end else if (valid_i && advance_i) begin
      last_index_q <= last_index_d;
      position_q   <= position_d;
      scene_q      <= scene_d;
      running_q    <= running_d;
      target_q     <= target_d;
      count_q      <= count_d;
    end
  end

  `CCC_ASSERT(a_count_bound, count_q <= target_q, "pulse count passed its target")
  `CCC_ASSERT_NEXT(a_start_runs, valid_i && advance_i && res_valid_o && res_o.motor_start,
    running_q && count_q == '0, "started move is not running from zero")
  `CCC_ASSERT(a_done_clean, !(res_valid_o && res_o.kind == KindDone)
    || (res_o.payload_len == '0 && !res_o.motor_start), "motor done item carries reply data")
  `CCC_ASSERT(a_pos_legal, position_q != 2'd3, "position left the legal range")

endmodule

@@ sv/curtain_command_controller.sv @@
// Curtain command controller.
// item_in carries either a received 5-byte command frame (address, index,
// command, two arguments) or one step-timer tick. result_out carries reply
// items (index, payload length, 1 or 3 payload bytes) plus motor start
// information, or a motor-finished item. Frames for another address or with
// a repeated index give no item; a tick gives one only when a move ends.
// Items are registered at the input, decided by one pass of logic against
// the state registers and registered at the output, so a result reaches
// result_out through the input and output registers; one item is taken
// every cycle while the output register is free or result_out.ready is high.
// While the output register holds a result and result_out.ready is low, the
// input stage holds its item; item_in.ready drops only then, with both
// stages full.
// cfg_we_i/cfg_idx_i/cfg_wdata_i write the five configuration registers;
// write them only while no item is in flight.
// Reset clears the last index, sets the position to open, scene bytes to
// 'b',0,0, stops the motor and loads the configuration reset values.
// Depends on ccc_pkg, ccc_if, ccc_cfg_regs, ccc_cmd_core and the macro header.
`include "curtain_command_controller_macros.svh"

module curtain_command_controller #(
  parameter int SCENE_SLOTS = ccc_pkg::SceneSlotsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ccc_in_if.sink                       item_in,
  ccc_out_if.source                    result_out,
  input  logic                         cfg_we_i,
  input  logic [ccc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ccc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import ccc_pkg::*;

  ccc_cfg_t    cfg;
  logic        in_valid_q;
  ccc_item_t   in_item_q;
  logic        out_valid_q;
  ccc_result_t out_res_q;
  logic        advance;
  logic        core_valid;
  ccc_result_t core_res;

  ccc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ccc_cmd_core #(
    .SCENE_SLOTS (SCENE_SLOTS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_q),
    .advance_i   (advance),
    .item_i      (in_item_q),
    .cfg_i       (cfg),
    .res_valid_o (core_valid),
    .res_o       (core_res)
  );

  // Advance the input stage whenever the output register is free or drains
  assign advance       = !out_valid_q || result_out.ready;
  assign item_in.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (item_in.ready) begin
        in_valid_q <= item_in.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q && core_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_in.valid && item_in.ready) begin
      in_item_q <= item_in.item;
    end
    if (advance) begin
      out_res_q <= core_res;
    end
  end

  assign result_out.valid = out_valid_q;
  assign result_out.res   = out_res_q;

  `CCC_ASSERT_NEXT(a_hold_input, in_valid_q && !advance, in_valid_q,
    "stalled item left the input stage")
  `CCC_ASSERT_NEXT(a_result_from_item, !in_valid_q && advance, !out_valid_q,
    "result produced without an item")
  `CCC_ASSERT(a_ready_when_free, in_valid_q || item_in.ready, "input refused while empty")

endmodule
